// File: sv/rbsd_pkg.sv
// shared types, widths and helpers for the rigid body state derivative block
package rbsd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NW        = 63;
  localparam int QW        = FRAC_BITS + 1;
  localparam int RW        = FRAC_BITS + 2;
  localparam int NUM_DIV   = 9;
  localparam int TBW       = RW + 32;
  localparam int TCW       = RW + 34;
  localparam int TDW       = 64 - FRAC_BITS;
  localparam int TGW       = TDW + 2;

  localparam logic [1:0] REG_INV_MASS = 2'd0;
  localparam logic [1:0] REG_INV_IX   = 2'd1;
  localparam logic [1:0] REG_INV_IY   = 2'd2;
  localparam logic [1:0] REG_INV_IZ   = 2'd3;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] ang_momentum_x;
    logic signed [31:0] ang_momentum_y;
    logic signed [31:0] ang_momentum_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] qdot_w;
    logic signed [31:0] qdot_x;
    logic signed [31:0] qdot_y;
    logic signed [31:0] qdot_z;
    logic               zero_quat_error;
  } out_word_t;

  typedef struct packed {
    logic [3:0][31:0] quat;
    logic [2:0][31:0] ang;
    logic [2:0][31:0] vel;
    logic             zero;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// File: sv/rbsd_div.sv
// pipelined fractional divider, one quotient bit per stage, nine lanes on one divisor
module rbsd_div (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   in_valid,
  input  logic [rbsd_pkg::NUM_DIV-1:0][rbsd_pkg::NW-1:0]         in_mag,
  input  logic [rbsd_pkg::NUM_DIV-1:0]                           in_neg,
  input  logic [rbsd_pkg::NW-1:0]                                in_den,
  input  rbsd_pkg::side_t                                        in_side,
  output logic                                                   out_valid,
  output logic [rbsd_pkg::NUM_DIV-1:0][rbsd_pkg::RW-1:0]         out_rot,
  output rbsd_pkg::side_t                                        out_side
);

  localparam int QW = rbsd_pkg::QW;
  localparam int NW = rbsd_pkg::NW;
  localparam int ND = rbsd_pkg::NUM_DIV;

  logic                         vld_r  [QW];
  logic [NW-1:0]                den_r  [QW];
  logic [ND-1:0]                neg_r  [QW];
  logic [ND-1:0][NW-1:0]        rem_r  [QW];
  logic [ND-1:0][QW-1:0]        quo_r  [QW];
  rbsd_pkg::side_t              side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                  v_in;
    logic [NW-1:0]         d_in;
    logic [ND-1:0]         n_in;
    rbsd_pkg::side_t       s_in;
    logic [ND-1:0][NW-1:0] trial;
    logic [ND-1:0][QW-1:0] q_in;
    logic [ND-1:0][NW-1:0] rem_nxt;
    logic [ND-1:0][QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign v_in  = in_valid;
      assign d_in  = in_den;
      assign n_in  = in_neg;
      assign s_in  = in_side;
      assign trial = in_mag;
      assign q_in  = '0;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign d_in = den_r[k-1];
      assign n_in = neg_r[k-1];
      assign s_in = side_r[k-1];
      assign q_in = quo_r[k-1];
      for (genvar i = 0; i < ND; i++) begin : g_shift
        assign trial[i] = {rem_r[k-1][i][NW-2:0], 1'b0};
      end
    end

    always_comb begin
      for (int i = 0; i < ND; i++) begin
        if (trial[i] >= d_in) begin
          rem_nxt[i] = trial[i] - d_in;
          quo_nxt[i] = {q_in[i][QW-2:0], 1'b1};
        end else begin
          rem_nxt[i] = trial[i];
          quo_nxt[i] = {q_in[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
      if (en) begin
        den_r[k]  <= d_in;
        neg_r[k]  <= n_in;
        side_r[k] <= s_in;
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_side  = side_r[QW-1];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (neg_r[QW-1][i]) begin
        out_rot[i] = -{1'b0, quo_r[QW-1][i]};
      end else begin
        out_rot[i] = {1'b0, quo_r[QW-1][i]};
      end
    end
  end

endmodule

// File: sv/rigid_body_state_derivative.sv
// top level: rigid body velocity and quaternion derivative pipeline
// One body enters as one word on the in_ channel (in_valid, in_stall) and its
// velocity and quaternion derivative leave as one word on the out_ channel
// (out_valid, out_stall). A word is taken at an edge with valid high, stall low.
// The cfg_ channel writes inverse mass and the body inverse inertia diagonal;
// cfg_ready is always high and writes belong to idle periods.
// Throughput is one body per cycle while no waiting result is stalled. Values are
// Q16.16. From acceptance to out_valid: three stages build |q|^2 and the
// rotation numerators, the divider resolves one quotient bit per stage
// (FRAC_BITS + 1 stages), six stages form the world inverse inertia, omega and
// the quaternion product, and one output register holds the result.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Synchronous reset clears every valid bit and sets all four registers to 1.0.
// A zero quaternion gives zero quaternion derivatives and raises zero_quat_error.
module rigid_body_state_derivative (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rbsd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output rbsd_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  localparam int F   = rbsd_pkg::FRAC_BITS;
  localparam int NW  = rbsd_pkg::NW;
  localparam int RW  = rbsd_pkg::RW;
  localparam int ND  = rbsd_pkg::NUM_DIV;
  localparam int TBW = rbsd_pkg::TBW;
  localparam int TCW = rbsd_pkg::TCW;
  localparam int TDW = rbsd_pkg::TDW;
  localparam int TGW = rbsd_pkg::TGW;
  localparam int NP  = 6;

  localparam int PAIR_I [NP] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [NP] = '{0, 1, 2, 1, 2, 2};
  localparam int PAIR_OF [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

  logic en;

  logic [30:0] inv_mass_r;
  logic [30:0] inertia_r [3];

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r   <= 31'd65536;
      inertia_r[0] <= 31'd65536;
      inertia_r[1] <= 31'd65536;
      inertia_r[2] <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbsd_pkg::REG_INV_MASS: inv_mass_r   <= cfg_data;
        rbsd_pkg::REG_INV_IX:   inertia_r[0] <= cfg_data;
        rbsd_pkg::REG_INV_IY:   inertia_r[1] <= cfg_data;
        rbsd_pkg::REG_INV_IZ:   inertia_r[2] <= cfg_data;
        default:                inv_mass_r   <= inv_mass_r;
      endcase
    end
  end

  logic out_valid_r;
  rbsd_pkg::out_word_t out_word_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // stage 1: prescale, quaternion products, momentum products
  logic signed [31:0] qin [4];
  logic signed [31:0] s [4];
  logic               big;
  logic               zero;
  logic signed [63:0] pr_nxt [10];
  logic signed [63:0] vm_nxt [3];

  assign qin[0] = in_word.quat_w;
  assign qin[1] = in_word.quat_x;
  assign qin[2] = in_word.quat_y;
  assign qin[3] = in_word.quat_z;

  always_comb begin
    big  = 1'b0;
    zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (qin[i] > 32'sd1073741824 || qin[i] < -32'sd1073741824) begin
        big = 1'b1;
      end
      if (qin[i] != 32'sd0) begin
        zero = 1'b0;
      end
    end
    for (int i = 0; i < 4; i++) begin
      s[i] = big ? (qin[i] >>> 1) : qin[i];
    end
    pr_nxt[0] = s[0] * s[0];
    pr_nxt[1] = s[1] * s[1];
    pr_nxt[2] = s[2] * s[2];
    pr_nxt[3] = s[3] * s[3];
    pr_nxt[4] = s[1] * s[2];
    pr_nxt[5] = s[0] * s[3];
    pr_nxt[6] = s[1] * s[3];
    pr_nxt[7] = s[0] * s[2];
    pr_nxt[8] = s[2] * s[3];
    pr_nxt[9] = s[0] * s[1];
    vm_nxt[0] = $signed({1'b0, inv_mass_r}) * in_word.momentum_x;
    vm_nxt[1] = $signed({1'b0, inv_mass_r}) * in_word.momentum_y;
    vm_nxt[2] = $signed({1'b0, inv_mass_r}) * in_word.momentum_z;
  end

  logic               s1_valid_r;
  logic signed [63:0] pr_r [10];
  logic signed [63:0] vm_r [3];
  rbsd_pkg::side_t    s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
    if (en) begin
      pr_r <= pr_nxt;
      vm_r <= vm_nxt;
      s1_side_r.quat <= {in_word.quat_z, in_word.quat_y, in_word.quat_x, in_word.quat_w};
      s1_side_r.ang  <= {in_word.ang_momentum_z, in_word.ang_momentum_y,
                         in_word.ang_momentum_x};
      s1_side_r.vel  <= '0;
      s1_side_r.zero <= zero;
    end
  end

  // stage 2: norm, rotation numerators, velocity saturation
  logic signed [63:0] num_nxt [ND];
  logic signed [63:0] nrm_nxt;
  rbsd_pkg::side_t    s2_side_nxt;

  always_comb begin
    nrm_nxt    = pr_r[0] + pr_r[1] + pr_r[2] + pr_r[3];
    num_nxt[0] = pr_r[0] + pr_r[1] - pr_r[2] - pr_r[3];
    num_nxt[1] = (pr_r[4] - pr_r[5]) <<< 1;
    num_nxt[2] = (pr_r[6] + pr_r[7]) <<< 1;
    num_nxt[3] = (pr_r[4] + pr_r[5]) <<< 1;
    num_nxt[4] = pr_r[0] - pr_r[1] + pr_r[2] - pr_r[3];
    num_nxt[5] = (pr_r[8] - pr_r[9]) <<< 1;
    num_nxt[6] = (pr_r[6] - pr_r[7]) <<< 1;
    num_nxt[7] = (pr_r[8] + pr_r[9]) <<< 1;
    num_nxt[8] = pr_r[0] - pr_r[1] - pr_r[2] + pr_r[3];
    s2_side_nxt = s1_side_r;
    for (int i = 0; i < 3; i++) begin
      s2_side_nxt.vel[i] = rbsd_pkg::sat32(vm_r[i] >>> F);
    end
  end

  logic               s2_valid_r;
  logic signed [63:0] num_r [ND];
  logic signed [63:0] nrm_r;
  rbsd_pkg::side_t    s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      num_r     <= num_nxt;
      nrm_r     <= nrm_nxt;
      s2_side_r <= s2_side_nxt;
    end
  end

  // stage 3: sign and magnitude
  logic [ND-1:0][NW-1:0] mag_nxt;
  logic [ND-1:0]         neg_nxt;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      neg_nxt[i] = num_r[i][63];
      mag_nxt[i] = num_r[i][63] ? NW'(-num_r[i]) : NW'(num_r[i]);
    end
  end

  logic                  s3_valid_r;
  logic [ND-1:0][NW-1:0] mag_r;
  logic [ND-1:0]         neg_r;
  logic [NW-1:0]         den_r;
  rbsd_pkg::side_t       s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
    if (en) begin
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      den_r     <= nrm_r[NW-1:0];
      s3_side_r <= s2_side_r;
    end
  end

  logic                  div_valid;
  logic [ND-1:0][RW-1:0] div_rot;
  rbsd_pkg::side_t       div_side;

  rbsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_mag    (mag_r),
    .in_neg    (neg_r),
    .in_den    (den_r),
    .in_side   (s3_side_r),
    .out_valid (div_valid),
    .out_rot   (div_rot),
    .out_side  (div_side)
  );

  // stage a: rotation entry products
  logic signed [2*RW-1:0] ta_prod [NP][3];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < 3; k++) begin
        ta_prod[p][k] = $signed(div_rot[PAIR_I[p]*3+k]) * $signed(div_rot[PAIR_J[p]*3+k]);
      end
    end
  end

  logic                 sa_valid_r;
  logic signed [RW-1:0] ta_r [NP][3];
  rbsd_pkg::side_t      sa_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (en) begin
      sa_valid_r <= div_valid;
    end
    if (en) begin
      for (int p = 0; p < NP; p++) begin
        for (int k = 0; k < 3; k++) begin
          ta_r[p][k] <= ta_prod[p][k][F+RW-1:F];
        end
      end
      sa_side_r <= div_side;
    end
  end

  // stage b: scale by body inverse inertia
  logic                  sb_valid_r;
  logic signed [TBW-1:0] tb_r [NP][3];
  rbsd_pkg::side_t       sb_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (en) begin
      sb_valid_r <= sa_valid_r;
    end
    if (en) begin
      for (int p = 0; p < NP; p++) begin
        for (int k = 0; k < 3; k++) begin
          tb_r[p][k] <= ta_r[p][k] * $signed({1'b0, inertia_r[k]});
        end
      end
      sb_side_r <= sa_side_r;
    end
  end

  // stage c: world inverse inertia
  logic signed [TCW-1:0] tc_sum [NP];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      tc_sum[p] = TCW'(tb_r[p][0]) + TCW'(tb_r[p][1]) + TCW'(tb_r[p][2]);
    end
  end

  logic               sc_valid_r;
  logic signed [31:0] iw_r [NP];
  rbsd_pkg::side_t    sc_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (en) begin
      sc_valid_r <= sb_valid_r;
    end
    if (en) begin
      for (int p = 0; p < NP; p++) begin
        iw_r[p] <= rbsd_pkg::sat32(64'(tc_sum[p] >>> F));
      end
      sc_side_r <= sb_side_r;
    end
  end

  // stage d: inertia times angular momentum
  logic signed [63:0] td_prod [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        td_prod[i][j] = iw_r[PAIR_OF[i][j]] * $signed(sc_side_r.ang[j]);
      end
    end
  end

  logic                  sd_valid_r;
  logic signed [TDW-1:0] td_r [3][3];
  rbsd_pkg::side_t       sd_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_valid_r <= 1'b0;
    end else if (en) begin
      sd_valid_r <= sc_valid_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          td_r[i][j] <= td_prod[i][j][63:F];
        end
      end
      sd_side_r <= sc_side_r;
    end
  end

  // stage e: omega
  logic signed [TGW-1:0] te_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      te_sum[i] = TGW'(td_r[i][0]) + TGW'(td_r[i][1]) + TGW'(td_r[i][2]);
    end
  end

  logic               se_valid_r;
  logic signed [31:0] om_r [3];
  rbsd_pkg::side_t    se_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_valid_r <= 1'b0;
    end else if (en) begin
      se_valid_r <= sd_valid_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        om_r[i] <= rbsd_pkg::sat32(64'(te_sum[i]));
      end
      se_side_r <= sd_side_r;
    end
  end

  // stage f: omega times raw quaternion
  logic signed [63:0] tf_prod [3][4];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 4; b++) begin
        tf_prod[a][b] = om_r[a] * $signed(se_side_r.quat[b]);
      end
    end
  end

  logic                  sf_valid_r;
  logic signed [TDW-1:0] tf_r [3][4];
  rbsd_pkg::side_t       sf_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_valid_r <= 1'b0;
    end else if (en) begin
      sf_valid_r <= se_valid_r;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 4; b++) begin
          tf_r[a][b] <= tf_prod[a][b][63:F];
        end
      end
      sf_side_r <= se_side_r;
    end
  end

  // output stage: quaternion derivative sums
  logic signed [TGW-1:0] qd [4];
  rbsd_pkg::out_word_t   out_word_nxt;

  always_comb begin
    qd[0] = -TGW'(tf_r[0][1]) - TGW'(tf_r[1][2]) - TGW'(tf_r[2][3]);
    qd[1] =  TGW'(tf_r[0][0]) + TGW'(tf_r[1][3]) - TGW'(tf_r[2][2]);
    qd[2] =  TGW'(tf_r[1][0]) + TGW'(tf_r[2][1]) - TGW'(tf_r[0][3]);
    qd[3] =  TGW'(tf_r[2][0]) + TGW'(tf_r[0][2]) - TGW'(tf_r[1][1]);
    out_word_nxt.vel_x = $signed(sf_side_r.vel[0]);
    out_word_nxt.vel_y = $signed(sf_side_r.vel[1]);
    out_word_nxt.vel_z = $signed(sf_side_r.vel[2]);
    out_word_nxt.zero_quat_error = sf_side_r.zero;
    if (sf_side_r.zero) begin
      out_word_nxt.qdot_w = '0;
      out_word_nxt.qdot_x = '0;
      out_word_nxt.qdot_y = '0;
      out_word_nxt.qdot_z = '0;
    end else begin
      out_word_nxt.qdot_w = rbsd_pkg::sat32(64'(qd[0] >>> 1));
      out_word_nxt.qdot_x = rbsd_pkg::sat32(64'(qd[1] >>> 1));
      out_word_nxt.qdot_y = rbsd_pkg::sat32(64'(qd[2] >>> 1));
      out_word_nxt.qdot_z = rbsd_pkg::sat32(64'(qd[3] >>> 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sf_valid_r;
    end
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

// File: tb/tb_rigid_body_state_derivative.sv
// testbench for the rigid body state derivative pipeline: checks velocity, qdot and zero flag
module tb_rigid_body_state_derivative;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCALE    = rbsd_pkg::FRAC_BITS;
  localparam int LATENCY  = rbsd_pkg::FRAC_BITS + 11;
  localparam int MAX_CYC  = 400000;
  localparam logic [30:0] FULL_REG = 31'h7fffffff;

  class deriv_scoreboard;
    rbsd_pkg::out_word_t deriv_q[$];
    longint    inv_mass;
    longint    inv_inertia[3];
    int        mismatches;
    int        checked;
    int        zero_seen;

    function void reset_regs();
      inv_mass = 65536;
      foreach (inv_inertia[i]) inv_inertia[i] = 65536;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        rbsd_pkg::REG_INV_MASS: inv_mass       = longint'(val);
        rbsd_pkg::REG_INV_IX:   inv_inertia[0] = longint'(val);
        rbsd_pkg::REG_INV_IY:   inv_inertia[1] = longint'(val);
        rbsd_pkg::REG_INV_IZ:   inv_inertia[2] = longint'(val);
        default:                inv_mass       = inv_mass;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // num * 2^F / den, truncated toward zero
    function longint rot_div(longint num, longint den);
      bit [63:0] mag, qt, rm, d;
      mag = num < 0 ? -num : num;
      d = den;
      qt = mag / d;
      rm = mag % d;
      for (int i = 0; i < SCALE; i++) begin
        rm = rm << 1;
        qt = qt << 1;
        if (rm >= d) begin
          rm = rm - d;
          qt[0] = 1'b1;
        end
      end
      return num < 0 ? -longint'(qt) : longint'(qt);
    endfunction

    function rbsd_pkg::out_word_t derive(rbsd_pkg::in_word_t w);
      rbsd_pkg::out_word_t o;
      longint q[4], p[3], l[3], s[4], r[3][3], iw[3][3], om[3], qd[4];
      longint n, acc, ww, xx, yy, zz;
      bit big;
      q[0] = longint'(w.quat_w); q[1] = longint'(w.quat_x);
      q[2] = longint'(w.quat_y); q[3] = longint'(w.quat_z);
      p[0] = longint'(w.momentum_x); p[1] = longint'(w.momentum_y);
      p[2] = longint'(w.momentum_z);
      l[0] = longint'(w.ang_momentum_x); l[1] = longint'(w.ang_momentum_y);
      l[2] = longint'(w.ang_momentum_z);
      o = '0;
      o.vel_x = 32'(clamp32((inv_mass * p[0]) >>> SCALE));
      o.vel_y = 32'(clamp32((inv_mass * p[1]) >>> SCALE));
      o.vel_z = 32'(clamp32((inv_mass * p[2]) >>> SCALE));
      big = 0;
      foreach (q[i]) if (q[i] > (64'sd1 << 30) || q[i] < -(64'sd1 << 30)) big = 1;
      foreach (q[i]) s[i] = big ? (q[i] >>> 1) : q[i];
      ww = s[0] * s[0]; xx = s[1] * s[1]; yy = s[2] * s[2]; zz = s[3] * s[3];
      n = ww + xx + yy + zz;
      if (n == 0) begin
        o.zero_quat_error = 1'b1;
        return o;
      end
      r[0][0] = rot_div(ww + xx - yy - zz, n);
      r[0][1] = rot_div(2 * (s[1] * s[2] - s[0] * s[3]), n);
      r[0][2] = rot_div(2 * (s[1] * s[3] + s[0] * s[2]), n);
      r[1][0] = rot_div(2 * (s[1] * s[2] + s[0] * s[3]), n);
      r[1][1] = rot_div(ww - xx + yy - zz, n);
      r[1][2] = rot_div(2 * (s[2] * s[3] - s[0] * s[1]), n);
      r[2][0] = rot_div(2 * (s[1] * s[3] - s[0] * s[2]), n);
      r[2][1] = rot_div(2 * (s[2] * s[3] + s[0] * s[1]), n);
      r[2][2] = rot_div(ww - xx - yy + zz, n);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += ((r[i][k] * r[j][k]) >>> SCALE) * inv_inertia[k];
          iw[i][j] = clamp32(acc >>> SCALE);
        end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += (iw[i][j] * l[j]) >>> SCALE;
        om[i] = clamp32(acc);
      end
      qd[0] = -((om[0] * q[1]) >>> SCALE) - ((om[1] * q[2]) >>> SCALE)
              - ((om[2] * q[3]) >>> SCALE);
      qd[1] = ((om[0] * q[0]) >>> SCALE) + ((om[1] * q[3]) >>> SCALE)
              - ((om[2] * q[2]) >>> SCALE);
      qd[2] = ((om[1] * q[0]) >>> SCALE) + ((om[2] * q[1]) >>> SCALE)
              - ((om[0] * q[3]) >>> SCALE);
      qd[3] = ((om[2] * q[0]) >>> SCALE) + ((om[0] * q[2]) >>> SCALE)
              - ((om[1] * q[1]) >>> SCALE);
      o.qdot_w = 32'(clamp32(qd[0] >>> 1));
      o.qdot_x = 32'(clamp32(qd[1] >>> 1));
      o.qdot_y = 32'(clamp32(qd[2] >>> 1));
      o.qdot_z = 32'(clamp32(qd[3] >>> 1));
      return o;
    endfunction

    function void note_body(rbsd_pkg::in_word_t w);
      deriv_q.push_back(derive(w));
    endfunction

    function void check_word(rbsd_pkg::out_word_t got);
      rbsd_pkg::out_word_t exp;
      bit bad;
      if (deriv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
        return;
      end
      exp = deriv_q.pop_front();
      checked++;
      if (got.zero_quat_error === 1'b1) zero_seen++;
      bad = exp.vel_x !== got.vel_x || exp.vel_y !== got.vel_y
         || exp.vel_z !== got.vel_z || exp.qdot_w !== got.qdot_w
         || exp.qdot_x !== got.qdot_x || exp.qdot_y !== got.qdot_y
         || exp.qdot_z !== got.qdot_z
         || exp.zero_quat_error !== got.zero_quat_error;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on word %0d", checked);
          $display("  exp vel %0d %0d %0d qdot %0d %0d %0d %0d zero %b",
                   exp.vel_x, exp.vel_y, exp.vel_z, exp.qdot_w, exp.qdot_x,
                   exp.qdot_y, exp.qdot_z, exp.zero_quat_error);
          $display("  got vel %0d %0d %0d qdot %0d %0d %0d %0d zero %b",
                   got.vel_x, got.vel_y, got.vel_z, got.qdot_w, got.qdot_x,
                   got.qdot_y, got.qdot_z, got.zero_quat_error);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rbsd_pkg::in_word_t  in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rbsd_pkg::out_word_t out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  deriv_scoreboard sb = new();
  int  cycles = 0;
  int  stall_mode = 0;
  int  hold_req = 0;
  int  hold_done = 0;
  int  hold_cnt = 0;
  int  bodies_sent = 0;
  int  burst_left = 0;

  always #1 clk = ~clk;

  rigid_body_state_derivative i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_done && hold_cnt == 0) begin
      hold_done = hold_done + 1;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (cycles % 7) < 2;
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic send_body(rbsd_pkg::in_word_t w);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_body(w);
    bodies_sent++;
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.deriv_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_regs(logic [30:0] m, logic [30:0] ix, logic [30:0] iy,
                            logic [30:0] iz);
    logic [30:0] vals[4];
    vals = '{m, ix, iy, iz};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(i[1:0], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] span(int unsigned lim);
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  function automatic rbsd_pkg::in_word_t rand_body();
    rbsd_pkg::in_word_t w;
    int kind;
    kind = $urandom_range(0, 19);
    w.momentum_x = $urandom_range(0, 1) ? $urandom() : span(1 << 20);
    w.momentum_y = $urandom_range(0, 1) ? $urandom() : span(1 << 20);
    w.momentum_z = $urandom_range(0, 1) ? $urandom() : span(1 << 20);
    w.ang_momentum_x = $urandom_range(0, 2) == 0 ? $urandom() : span(1 << 19);
    w.ang_momentum_y = $urandom_range(0, 2) == 0 ? $urandom() : span(1 << 19);
    w.ang_momentum_z = $urandom_range(0, 2) == 0 ? $urandom() : span(1 << 19);
    if (kind == 0) begin
      w.quat_w = '0; w.quat_x = '0; w.quat_y = '0; w.quat_z = '0;
    end else if (kind < 6) begin
      w.quat_w = $urandom(); w.quat_x = $urandom();
      w.quat_y = $urandom(); w.quat_z = $urandom();
    end else if (kind < 9) begin
      w.quat_w = span(1 << 30); w.quat_x = span(1 << 30);
      w.quat_y = span(1 << 30); w.quat_z = span(1 << 30);
    end else begin
      w.quat_w = span(1 << 16); w.quat_x = span(1 << 16);
      w.quat_y = span(1 << 16); w.quat_z = span(1 << 16);
    end
    return w;
  endfunction

  function automatic rbsd_pkg::in_word_t mk_body(logic [31:0] qw, logic [31:0] qx,
                                                 logic [31:0] qy, logic [31:0] qz,
                                                 logic [31:0] pv, logic [31:0] lv);
    rbsd_pkg::in_word_t w;
    w.quat_w = qw; w.quat_x = qx; w.quat_y = qy; w.quat_z = qz;
    w.momentum_x = pv; w.momentum_y = -pv; w.momentum_z = pv >>> 3;
    w.ang_momentum_x = lv; w.ang_momentum_y = lv >>> 2; w.ang_momentum_z = -lv;
    return w;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_body(rand_body());
  endtask

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] LIM  = 32'h4000_0000;

  initial begin
    sb.reset_regs();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed bodies at reset registers
    send_body(mk_body(ONE, 0, 0, 0, ONE, ONE));
    send_body(mk_body(0, 0, 0, 0, MAXV, MAXV));
    send_body(mk_body(0, 0, 0, 0, MINV, MINV));
    send_body(mk_body(0, ONE, 0, 0, ONE, 32'h0003_0000));
    send_body(mk_body(0, 0, ONE, 0, MINV, ONE));
    send_body(mk_body(0, 0, 0, ONE, MAXV, -ONE));
    send_body(mk_body(32'h0000_b505, 32'h0000_b505, 0, 0, 32'h1234_5678, ONE));
    send_body(mk_body(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send_body(mk_body(MINV, MINV, MINV, MINV, MINV, MINV));
    send_body(mk_body(MAXV, MINV, 0, ONE, ONE, MINV));
    send_body(mk_body(LIM, LIM, -LIM, LIM, ONE, MAXV));
    send_body(mk_body(LIM + 1, 0, 0, 0, ONE, ONE));
    send_body(mk_body(-LIM - 1, 0, 0, 0, -ONE, ONE));
    send_body(mk_body(1, 0, 0, 0, 1, 1));
    send_body(mk_body(-1, 1, -1, 1, -1, MAXV));
    send_body(mk_body(ONE, ONE, ONE, ONE, 32'hffff_ffff, 32'h7fff_0000));
    send_body(mk_body(0, 0, 0, 0, 0, 0));
    send_body(mk_body(32'h0000_8000, 0, 32'h0000_8000, 0, ONE, ONE));
    stall_mode = 1;
    run_random(300);
    drain();

    write_regs(FULL_REG, FULL_REG, FULL_REG, FULL_REG);
    stall_mode = 2;
    for (int i = 0; i < 4; i++) begin
      send_body(mk_body(ONE, 0, 0, 0, MAXV, MAXV));
      send_body(mk_body(0, ONE, ONE, 0, MINV, MINV));
    end
    run_random(290);
    drain();

    write_regs('0, '0, '0, '0);
    stall_mode = 0;
    run_random(250);
    drain();

    write_regs(31'($urandom()), 31'($urandom_range(0, 1 << 20)), 31'($urandom()),
               31'($urandom_range(0, 1 << 17)));
    stall_mode = 1;
    run_random(100);
    hold_req++;
    run_random(150);
    // let every result out before continuing
    in_valid <= 1'b0;
    while (sb.deriv_q.size() != 0) @(posedge clk);
    run_random(150);
    drain();

    write_regs(31'($urandom_range(0, 1 << 18)), 31'($urandom_range(1 << 15, 1 << 17)),
               31'($urandom_range(1 << 15, 1 << 17)), FULL_REG);
    stall_mode = 3;
    run_random(200);
    stall_mode = 1;
    hold_req++;
    run_random(200);
    drain();

    $display("covered %0d bodies over five register settings, %0d zero quaternions",
             bodies_sent, sb.zero_seen);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.deriv_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
